// File: rtl/adll_pkg.sv
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types, constants and the microcode ROM of the array doubly linked
// list.
// ----------------------------------------------------------------------------
package adll_pkg;

  // Store geometry: node slots 1..MAX_NODES, 0 is the left end and
  // MAX_NODES+1 the right end.
  localparam int MAX_NODES = 1024;
  localparam int AW        = $clog2(MAX_NODES);
  localparam int HW        = $clog2(MAX_NODES + 2);
  localparam int VW        = 32;

  typedef logic [HW-1:0] hdl_t;

  localparam hdl_t LEFT_END  = hdl_t'(0);
  localparam hdl_t RIGHT_END = hdl_t'(MAX_NODES + 1);
  localparam hdl_t MAX_HDL   = hdl_t'(MAX_NODES);

  typedef enum logic [2:0] {
    OP_PUSHL = 3'd0,
    OP_PUSHR = 3'd1,
    OP_DEL   = 3'd2,
    OP_INSL  = 3'd3,
    OP_INSR  = 3'd4,
    OP_WALK  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BADH = 2'd2
  } st_t;

  // Microcode step addresses
  typedef enum logic [4:0] {
    S_PL   = 5'd0,
    S_PR   = 5'd1,
    S_DEL0 = 5'd2,
    S_DEL1 = 5'd3,
    S_DEL2 = 5'd4,
    S_IL0  = 5'd5,
    S_IL1  = 5'd6,
    S_IR0  = 5'd7,
    S_IR1  = 5'd8,
    S_LNK0 = 5'd9,
    S_LNK1 = 5'd10,
    S_WK0  = 5'd11,
    S_WK1  = 5'd12,
    S_WK2  = 5'd13,
    S_WK3  = 5'd14,
    S_WEND = 5'd15,
    S_FAIL = 5'd16
  } step_t;

  // Jump conditions
  typedef enum logic [1:0] {
    C_NONE = 2'd0,
    C_FAIL = 2'd1,
    C_END  = 2'd2
  } cond_t;

  // Neighbor register loads
  typedef enum logic [2:0] {
    AB_HOLD  = 3'd0,
    AB_PUSHL = 3'd1,
    AB_PUSHR = 3'd2,
    AB_INSL  = 3'd3,
    AB_INSR  = 3'd4,
    AB_DEL   = 3'd5,
    AB_WALK  = 3'd6
  } ab_t;

  // Neighbor link writes
  typedef enum logic [1:0] {
    NBR_NONE = 2'd0,
    NBR_INS  = 2'd1,
    NBR_DEL  = 2'd2
  } nbr_t;

  // Result formats
  typedef enum logic [2:0] {
    E_NONE  = 3'd0,
    E_PLAIN = 3'd1,
    E_INS   = 3'd2,
    E_WALK  = 3'd3,
    E_WEND  = 3'd4
  } emit_t;

  typedef struct packed {
    step_t nxt;
    step_t jmp;
    cond_t cond;
    logic  rd_link;
    logic  rd_val;
    logic  chk_h;
    logic  allow_zero;
    logic  chk_full;
    ab_t   ab;
    logic  wr_node;
    nbr_t  nbr;
    emit_t emit;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic fail;
    logic at_end;
    logic out_free;
  } dp_flags_t;

  localparam ucode_t UC_NOP = '{
    nxt: S_FAIL, jmp: S_FAIL, cond: C_NONE, rd_link: 1'b0, rd_val: 1'b0,
    chk_h: 1'b0, allow_zero: 1'b0, chk_full: 1'b0, ab: AB_HOLD,
    wr_node: 1'b0, nbr: NBR_NONE, emit: E_NONE
  };

  // Entry point of each operation's program
  function automatic step_t entry(logic [2:0] opcode);
    step_t s;
    s = S_FAIL;
    unique case (op_t'(opcode))
      OP_PUSHL: s = S_PL;
      OP_PUSHR: s = S_PR;
      OP_DEL:   s = S_DEL0;
      OP_INSL:  s = S_IL0;
      OP_INSR:  s = S_IR0;
      OP_WALK:  s = S_WK0;
      default:  s = S_FAIL;
    endcase
    return s;
  endfunction

  // Control store
  function automatic ucode_t ucode(step_t s);
    ucode_t u;
    u = UC_NOP;
    unique case (s)
      S_PL: begin
        u.chk_full = 1'b1; u.ab = AB_PUSHL;
        u.cond = C_FAIL; u.jmp = S_FAIL; u.nxt = S_LNK0;
      end
      S_PR: begin
        u.chk_full = 1'b1; u.ab = AB_PUSHR;
        u.cond = C_FAIL; u.jmp = S_FAIL; u.nxt = S_LNK0;
      end
      S_DEL0: begin
        u.rd_link = 1'b1; u.nxt = S_DEL1;
      end
      S_DEL1: begin
        u.chk_h = 1'b1; u.ab = AB_DEL;
        u.cond = C_FAIL; u.jmp = S_FAIL; u.nxt = S_DEL2;
      end
      S_DEL2: begin
        u.nbr = NBR_DEL; u.emit = E_PLAIN;
      end
      S_IL0: begin
        u.rd_link = 1'b1; u.nxt = S_IL1;
      end
      S_IL1: begin
        u.chk_h = 1'b1; u.chk_full = 1'b1; u.ab = AB_INSL;
        u.cond = C_FAIL; u.jmp = S_FAIL; u.nxt = S_LNK0;
      end
      S_IR0: begin
        u.rd_link = 1'b1; u.nxt = S_IR1;
      end
      S_IR1: begin
        u.chk_h = 1'b1; u.chk_full = 1'b1; u.ab = AB_INSR;
        u.cond = C_FAIL; u.jmp = S_FAIL; u.nxt = S_LNK0;
      end
      S_LNK0: begin
        u.wr_node = 1'b1; u.nxt = S_LNK1;
      end
      S_LNK1: begin
        u.nbr = NBR_INS; u.emit = E_INS;
      end
      S_WK0: begin
        u.rd_link = 1'b1; u.nxt = S_WK1;
      end
      S_WK1: begin
        u.chk_h = 1'b1; u.allow_zero = 1'b1; u.ab = AB_WALK;
        u.cond = C_FAIL; u.jmp = S_FAIL; u.nxt = S_WK2;
      end
      S_WK2: begin
        u.rd_val = 1'b1; u.cond = C_END; u.jmp = S_WEND; u.nxt = S_WK3;
      end
      S_WK3:   u.emit = E_WALK;
      S_WEND:  u.emit = E_WEND;
      S_FAIL:  u.emit = E_PLAIN;
      default: u.emit = E_PLAIN;
    endcase
    return u;
  endfunction

endpackage

// File: rtl/adll_seq.sv
// ----------------------------------------------------------------------------
// adll_seq
// Step counter and control store: dispatches on the opcode and walks the
// operation's program, one control word per cycle unless a result stalls.
// ----------------------------------------------------------------------------
module adll_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          opcode,
  input  adll_pkg::dp_flags_t flags,
  output logic                busy,
  output logic                fire,
  output adll_pkg::ucode_t    ctl
);

  adll_pkg::step_t step;
  logic            taken;
  logic            emits;

  // Fetch the control word
  always_comb begin
    ctl = busy ? adll_pkg::ucode(step) : adll_pkg::UC_NOP;
  end

  assign emits = ctl.emit != adll_pkg::E_NONE;

  // Hold a result step until the output register frees up
  assign fire = busy & (~emits | flags.out_free);

  // Evaluate the jump condition
  always_comb begin
    case (ctl.cond)
      adll_pkg::C_FAIL: taken = flags.fail;
      adll_pkg::C_END:  taken = flags.at_end;
      default:          taken = 1'b0;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= adll_pkg::S_FAIL;
    end else if (start) begin
      busy <= 1'b1;
      step <= adll_pkg::entry(opcode);
    end else if (fire) begin
      if (emits) begin
        busy <= 1'b0;
      end else begin
        step <= taken ? ctl.jmp : ctl.nxt;
      end
    end
  end

endmodule

// File: rtl/array_doubly_linked_list_top.sv
// ----------------------------------------------------------------------------
// array_doubly_linked_list_top
// Doubly linked list over link memories with left and right end sentinels.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives exactly one response. A request
// is accepted and then runs its microcode program. Delete, insert left or
// right of a node and walk first read the node's links; push left or right
// and insert then write the new node's links and, in a separate step, the
// neighbors' links, as each link memory has a single write port. A rejected
// request ends in S_FAIL. The response sits in an output register, so the
// next request is taken while it waits. No clearing pass follows reset: the
// insert count marks which handles were ever written, so the block takes
// requests at once.
module array_doubly_linked_list_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [2:0]                    opcode,
  input  logic [adll_pkg::HW-1:0]       handle,
  input  logic signed [adll_pkg::VW-1:0] value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [adll_pkg::HW-1:0]       new_handle,
  output logic [adll_pkg::HW-1:0]       next_handle,
  output logic signed [adll_pkg::VW-1:0] read_value,
  output logic                          at_end
);

  logic                busy;
  logic                fire;
  logic                req_acc;
  adll_pkg::ucode_t    ctl;
  adll_pkg::dp_flags_t flags;

  // Request registers and neighbor registers
  adll_pkg::hdl_t           h_r;
  logic [adll_pkg::VW-1:0]  v_r;
  adll_pkg::hdl_t           a_r;
  adll_pkg::hdl_t           b_r;
  adll_pkg::st_t            st;

  // Insert count and the sentinel links
  adll_pkg::hdl_t cnt;
  adll_pkg::hdl_t rl0;
  adll_pkg::hdl_t lle;

  // Link, value and live memories for node slots
  adll_pkg::hdl_t          lmem [adll_pkg::MAX_NODES];
  adll_pkg::hdl_t          rmem [adll_pkg::MAX_NODES];
  logic [adll_pkg::VW-1:0] vmem [adll_pkg::MAX_NODES];
  logic                    live_mem [adll_pkg::MAX_NODES];

  adll_pkg::hdl_t          ldat;
  adll_pkg::hdl_t          rdat;
  logic                    live_q;
  logic [adll_pkg::VW-1:0] vdat;

  logic                    l_we;
  logic [adll_pkg::AW-1:0] l_addr;
  adll_pkg::hdl_t          l_din;
  logic                    r_we;
  logic [adll_pkg::AW-1:0] r_addr;
  adll_pkg::hdl_t          r_din;
  logic                    lv_we;
  logic [adll_pkg::AW-1:0] lv_addr;
  logic                    lv_din;
  logic                    v_we;

  adll_pkg::hdl_t          n_new;
  adll_pkg::hdl_t          h_m1;
  adll_pkg::hdl_t          a_m1;
  adll_pkg::hdl_t          b_m1;
  logic [adll_pkg::AW-1:0] h_addr;
  logic [adll_pkg::AW-1:0] slot_addr;
  logic                    full;
  logic                    h_zero;
  logic                    bad_h;
  logic                    full_f;
  logic                    a_is_left;
  logic                    b_is_right;

  assign req_acc   = req_valid & ~busy;
  assign req_stall = busy;

  adll_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (req_acc),
    .opcode (opcode),
    .flags  (flags),
    .busy   (busy),
    .fire   (fire),
    .ctl    (ctl)
  );

  // Address and check logic
  assign n_new      = cnt + adll_pkg::hdl_t'(1);
  assign h_m1       = h_r - adll_pkg::hdl_t'(1);
  assign a_m1       = a_r - adll_pkg::hdl_t'(1);
  assign b_m1       = b_r - adll_pkg::hdl_t'(1);
  assign h_addr     = h_m1[adll_pkg::AW-1:0];
  assign slot_addr  = cnt[adll_pkg::AW-1:0];
  assign full       = cnt == adll_pkg::MAX_HDL;
  assign h_zero     = h_r == adll_pkg::LEFT_END;
  assign a_is_left  = a_r == adll_pkg::LEFT_END;
  assign b_is_right = b_r == adll_pkg::RIGHT_END;
  assign bad_h      = ctl.chk_h & ~(ctl.allow_zero & h_zero)
                    & (h_zero | (h_r > cnt) | ~live_q);
  assign full_f     = ctl.chk_full & full;

  assign flags.fail     = bad_h | full_f;
  assign flags.at_end   = (b_r == adll_pkg::LEFT_END) | (b_r > adll_pkg::MAX_HDL);
  assign flags.out_free = ~rsp_valid | ~rsp_stall;

  // Capture the request
  always_ff @(posedge clk) begin
    if (req_acc) begin
      h_r <= handle;
      v_r <= value;
    end
  end

  // Track the status code
  always_ff @(posedge clk) begin
    if (req_acc) begin
      st <= (opcode > 3'(adll_pkg::OP_WALK)) ? adll_pkg::ST_BADH : adll_pkg::ST_OK;
    end else if (fire & (ctl.chk_h | ctl.chk_full)) begin
      if (bad_h) begin
        st <= adll_pkg::ST_BADH;
      end else if (full_f) begin
        st <= adll_pkg::ST_FULL;
      end
    end
  end

  // Load the left and right neighbors
  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctl.ab)
        adll_pkg::AB_PUSHL: begin
          a_r <= adll_pkg::LEFT_END;
          b_r <= rl0;
        end
        adll_pkg::AB_PUSHR: begin
          a_r <= lle;
          b_r <= adll_pkg::RIGHT_END;
        end
        adll_pkg::AB_INSL: begin
          a_r <= ldat;
          b_r <= h_r;
        end
        adll_pkg::AB_INSR: begin
          a_r <= h_r;
          b_r <= rdat;
        end
        adll_pkg::AB_DEL: begin
          a_r <= ldat;
          b_r <= rdat;
        end
        adll_pkg::AB_WALK: begin
          b_r <= h_zero ? rl0 : rdat;
        end
        default: ;
      endcase
    end
  end

  // Update the insert count and the sentinel links
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rl0 <= adll_pkg::RIGHT_END;
      lle <= adll_pkg::LEFT_END;
    end else if (fire) begin
      case (ctl.nbr)
        adll_pkg::NBR_INS: begin
          cnt <= n_new;
          if (a_is_left) begin
            rl0 <= n_new;
          end
          if (b_is_right) begin
            lle <= n_new;
          end
        end
        adll_pkg::NBR_DEL: begin
          if (a_is_left) begin
            rl0 <= b_r;
          end
          if (b_is_right) begin
            lle <= a_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Steer the memory writes
  always_comb begin
    l_we    = 1'b0;
    l_addr  = b_m1[adll_pkg::AW-1:0];
    l_din   = a_r;
    r_we    = 1'b0;
    r_addr  = a_m1[adll_pkg::AW-1:0];
    r_din   = b_r;
    lv_we   = 1'b0;
    lv_addr = h_addr;
    lv_din  = 1'b0;
    if (fire) begin
      if (ctl.wr_node) begin
        l_we    = 1'b1;
        l_addr  = slot_addr;
        r_we    = 1'b1;
        r_addr  = slot_addr;
        lv_we   = 1'b1;
        lv_addr = slot_addr;
        lv_din  = 1'b1;
      end
      case (ctl.nbr)
        adll_pkg::NBR_INS: begin
          l_we  = ~b_is_right;
          l_din = n_new;
          r_we  = ~a_is_left;
          r_din = n_new;
        end
        adll_pkg::NBR_DEL: begin
          l_we  = ~b_is_right;
          r_we  = ~a_is_left;
          lv_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign v_we = fire & ctl.wr_node;

  // Left link memory
  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_addr] <= l_din;
    end
    if (ctl.rd_link) begin
      ldat <= lmem[h_addr];
    end
  end

  // Right link memory
  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_addr] <= r_din;
    end
    if (ctl.rd_link) begin
      rdat <= rmem[h_addr];
    end
  end

  // Live flag memory
  always_ff @(posedge clk) begin
    if (lv_we) begin
      live_mem[lv_addr] <= lv_din;
    end
    if (ctl.rd_link) begin
      live_q <= live_mem[h_addr];
    end
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[slot_addr] <= v_r;
    end
    if (ctl.rd_val) begin
      vdat <= vmem[b_m1[adll_pkg::AW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire && ctl.emit != adll_pkg::E_NONE) begin
      rsp_valid <= 1'b1;
    end else if (~rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Format the response
  always_ff @(posedge clk) begin
    if (fire && ctl.emit != adll_pkg::E_NONE) begin
      status      <= adll_pkg::ST_OK;
      new_handle  <= '0;
      next_handle <= '0;
      read_value  <= '0;
      at_end      <= 1'b0;
      case (ctl.emit)
        adll_pkg::E_PLAIN: status <= st;
        adll_pkg::E_INS:   new_handle <= n_new;
        adll_pkg::E_WALK: begin
          next_handle <= b_r;
          read_value  <= vdat;
        end
        adll_pkg::E_WEND:  at_end <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/adll_chk.sv
// ----------------------------------------------------------------------------
// adll_chk
// Port-level checks of the linked list block, bound to the top level.
// ----------------------------------------------------------------------------
module adll_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_stall,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic [1:0]                     status,
  input logic [adll_pkg::HW-1:0]        new_handle,
  input logic [adll_pkg::HW-1:0]        next_handle,
  input logic signed [adll_pkg::VW-1:0] read_value,
  input logic                           at_end
);

  // A taken request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while block still idle next cycle");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(new_handle)
      && $stable(next_handle) && $stable(read_value) && $stable(at_end))
    else $error("stalled response changed");

  // A rejected request reports nothing but its status
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != adll_pkg::ST_OK |-> new_handle == '0
      && next_handle == '0 && read_value == '0 && !at_end)
    else $error("rejected request carries data");

  // A walk off the right end carries no neighbor
  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && at_end |-> status == adll_pkg::ST_OK && next_handle == '0
      && read_value == '0 && new_handle == '0)
    else $error("walk at right end carries neighbor data");

endmodule

bind array_doubly_linked_list_top adll_chk u_adll_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .status      (status),
  .new_handle  (new_handle),
  .next_handle (next_handle),
  .read_value  (read_value),
  .at_end      (at_end)
);
